// ----- rtl/header_length_footer_deframer_unit_assert.svh -----
// Assertion macros for the deframer checks.
// Each expects clk and arst_n in scope.
`ifndef HEADER_LENGTH_FOOTER_DEFRAMER_UNIT_ASSERT_SVH
`define HEADER_LENGTH_FOOTER_DEFRAMER_UNIT_ASSERT_SVH

// same-cycle implication
`define HLFD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HLFD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/hlfd_pkg.sv -----
package hlfd_pkg;

	localparam int BYTE_BITS = 8;
	localparam int WORD_BITS = 32;
	localparam int LEN_BITS  = 21;

	localparam logic [WORD_BITS-1:0] HEADER_RESET      = 32'hBEEFFACE;
	localparam logic [WORD_BITS-1:0] FOOTER_RESET      = 32'hBAADF00D;
	localparam logic [LEN_BITS-1:0]  MAX_PAYLOAD_RESET = 21'd1000000;
	localparam logic [WORD_BITS-1:0] OVERHEAD_BYTES    = 32'd12;

	localparam logic [1:0] CFG_HEADER      = 2'd0;
	localparam logic [1:0] CFG_FOOTER      = 2'd1;
	localparam logic [1:0] CFG_MAX_PAYLOAD = 2'd2;

	localparam logic [1:0] EV_PAYLOAD  = 2'd0;
	localparam logic [1:0] EV_GOOD     = 2'd1;
	localparam logic [1:0] EV_BAD_FOOT = 2'd2;
	localparam logic [1:0] EV_BAD_LEN  = 2'd3;

	typedef struct packed {
		logic [WORD_BITS-1:0] header_word;
		logic [WORD_BITS-1:0] footer_word;
		logic [LEN_BITS-1:0]  max_payload;
	} cfg_t;

	typedef struct packed {
		logic [1:0]           event_kind;
		logic [BYTE_BITS-1:0] payload_byte;
		logic [LEN_BITS-1:0]  position;
		logic [LEN_BITS-1:0]  frame_payload_length;
	} res_t;

endpackage

// ----- rtl/hlfd_in_if.sv -----
interface hlfd_in_if;
	logic                          valid;
	logic                          ready;
	logic [hlfd_pkg::BYTE_BITS-1:0] rx_byte;

	modport source(output valid, output rx_byte, input ready);
	modport sink(input valid, input rx_byte, output ready);
endinterface

// ----- rtl/hlfd_out_if.sv -----
interface hlfd_out_if #(
	parameter int INDEX_BITS = 20
);
	logic                           valid;
	logic                           ready;
	logic [1:0]                     event_kind;
	logic [hlfd_pkg::BYTE_BITS-1:0] payload_byte;
	logic [INDEX_BITS-1:0]          byte_index;
	logic [hlfd_pkg::LEN_BITS-1:0]  frame_payload_length;

	modport source(output valid, output event_kind, output payload_byte,
		output byte_index, output frame_payload_length, input ready);
	modport sink(input valid, input event_kind, input payload_byte,
		input byte_index, input frame_payload_length, output ready);
endinterface

// ----- rtl/hlfd_cfg_regs.sv -----
module hlfd_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [1:0]                     cfg_index,
	input  logic [hlfd_pkg::WORD_BITS-1:0] cfg_wdata,
	output hlfd_pkg::cfg_t                 cfg
);
	import hlfd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_word <= HEADER_RESET;
			cfg_q.footer_word <= FOOTER_RESET;
			cfg_q.max_payload <= MAX_PAYLOAD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_HEADER:      cfg_q.header_word <= cfg_wdata;
				CFG_FOOTER:      cfg_q.footer_word <= cfg_wdata;
				CFG_MAX_PAYLOAD: cfg_q.max_payload <= cfg_wdata[LEN_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

// ----- rtl/hlfd_parser.sv -----
module hlfd_parser (
	input  logic                           clk,
	input  logic                           arst_n,
	input  hlfd_pkg::cfg_t                 cfg,
	input  logic                           in_fire,
	input  logic [hlfd_pkg::BYTE_BITS-1:0] rx_byte,
	output logic                           res_vld,
	output hlfd_pkg::res_t                 res
);
	import hlfd_pkg::*;

	localparam logic [1:0] MODE_HUNT    = 2'd0;
	localparam logic [1:0] MODE_LENGTH  = 2'd1;
	localparam logic [1:0] MODE_PAYLOAD = 2'd2;
	localparam logic [1:0] MODE_FOOTER  = 2'd3;
	localparam logic [1:0] FIELD_LAST   = 2'd3;

	logic [1:0]           mode_q, mode_d;
	logic [WORD_BITS-1:0] window_q, window_d;
	logic [1:0]           cnt_q, cnt_d;
	logic [LEN_BITS-1:0]  plen_q, plen_d;
	logic [LEN_BITS-1:0]  ppos_q, ppos_d;

	logic [WORD_BITS-1:0] win_next;
	logic [WORD_BITS-1:0] diff;
	logic                 len_bad;
	logic [LEN_BITS-1:0]  pos_inc;

	assign win_next = {rx_byte, window_q[WORD_BITS-1:BYTE_BITS]};
	assign diff     = win_next - OVERHEAD_BYTES;
	assign len_bad  = (win_next < OVERHEAD_BYTES) || (diff[WORD_BITS-1:LEN_BITS] != '0)
		|| (diff[LEN_BITS-1:0] > cfg.max_payload);
	assign pos_inc  = ppos_q + 1'b1;

	always_comb begin
		mode_d   = mode_q;
		window_d = window_q;
		cnt_d    = cnt_q;
		plen_d   = plen_q;
		ppos_d   = ppos_q;
		res_vld  = 1'b0;
		res      = '0;
		unique case (mode_q)
			MODE_HUNT: begin
				window_d = win_next;
				if (cnt_q != FIELD_LAST) begin
					cnt_d = cnt_q + 1'b1;
				end else if (win_next == cfg.header_word) begin
					mode_d   = MODE_LENGTH;
					window_d = '0;
					cnt_d    = '0;
				end
			end
			MODE_LENGTH: begin
				window_d = win_next;
				if (cnt_q != FIELD_LAST) begin
					cnt_d = cnt_q + 1'b1;
				end else if (len_bad) begin
					mode_d         = MODE_HUNT;
					window_d       = '0;
					cnt_d          = '0;
					res_vld        = 1'b1;
					res.event_kind = EV_BAD_LEN;
				end else begin
					plen_d   = diff[LEN_BITS-1:0];
					ppos_d   = '0;
					window_d = '0;
					cnt_d    = '0;
					mode_d   = (diff[LEN_BITS-1:0] == '0) ? MODE_FOOTER : MODE_PAYLOAD;
				end
			end
			MODE_PAYLOAD: begin
				res_vld                  = 1'b1;
				res.event_kind           = EV_PAYLOAD;
				res.payload_byte         = rx_byte;
				res.position             = ppos_q;
				res.frame_payload_length = plen_q;
				ppos_d                   = pos_inc;
				if (pos_inc >= plen_q) begin
					mode_d   = MODE_FOOTER;
					window_d = '0;
					cnt_d    = '0;
				end
			end
			MODE_FOOTER: begin
				window_d = win_next;
				if (cnt_q != FIELD_LAST) begin
					cnt_d = cnt_q + 1'b1;
				end else begin
					mode_d                   = MODE_HUNT;
					window_d                 = '0;
					cnt_d                    = '0;
					res_vld                  = 1'b1;
					res.event_kind           = (win_next == cfg.footer_word) ? EV_GOOD
						: EV_BAD_FOOT;
					res.frame_payload_length = plen_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_HUNT;
			window_q <= '0;
			cnt_q    <= '0;
			plen_q   <= '0;
			ppos_q   <= '0;
		end else if (in_fire) begin
			mode_q   <= mode_d;
			window_q <= window_d;
			cnt_q    <= cnt_d;
			plen_q   <= plen_d;
			ppos_q   <= ppos_d;
		end
	end
endmodule

// ----- rtl/hlfd_out_reg.sv -----
module hlfd_out_reg #(
	parameter int INDEX_BITS = 20
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_fire,
	input  logic                           res_vld,
	input  hlfd_pkg::res_t                 res,
	input  logic                           out_ready,
	output logic                           in_ready,
	output logic                           out_valid,
	output logic [1:0]                     event_kind,
	output logic [hlfd_pkg::BYTE_BITS-1:0] payload_byte,
	output logic [INDEX_BITS-1:0]          byte_index,
	output logic [hlfd_pkg::LEN_BITS-1:0]  frame_payload_length
);
	import hlfd_pkg::*;

	logic                  vld_q;
	res_t                  res_q;

	assign in_ready = !vld_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_fire) begin
			vld_q <= res_vld;
		end else if (out_ready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && res_vld) begin
			res_q <= res;
		end
	end

	assign out_valid            = vld_q;
	assign event_kind           = res_q.event_kind;
	assign payload_byte         = res_q.payload_byte;
	assign frame_payload_length = res_q.frame_payload_length;

	generate
		if (INDEX_BITS <= LEN_BITS) begin : g_idx_trunc
			assign byte_index = res_q.position[INDEX_BITS-1:0];
		end else begin : g_idx_ext
			assign byte_index = {{(INDEX_BITS-LEN_BITS){1'b0}}, res_q.position};
		end
	endgenerate
endmodule

// ----- rtl/header_length_footer_deframer_unit.sv -----
// A result is registered when its byte is accepted and shows on evt in the next cycle.
// Throughput: one byte per cycle; ready drops only while a result waits unread.
// Bytes that produce no result still advance the parser state.
// Reset (arst_n low, async): header hunting, window and counters cleared,
// registers back to 0xBEEFFACE / 0xBAADF00D / 1000000, no result pending.
module header_length_footer_deframer_unit #(
	parameter int PAYLOAD_INDEX_BITS = 20
) (
	input  logic                           clk,
	input  logic                           arst_n,
	hlfd_in_if.sink                        rx,
	hlfd_out_if.source                     evt,
	input  logic                           cfg_we,
	input  logic [1:0]                     cfg_index,
	input  logic [hlfd_pkg::WORD_BITS-1:0] cfg_wdata
);
	import hlfd_pkg::*;

	cfg_t cfg;
	logic in_ready;
	logic in_fire;
	logic res_vld;
	res_t res;

	assign in_fire  = rx.valid && in_ready;
	assign rx.ready = in_ready;

	hlfd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	hlfd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.in_fire (in_fire),
		.rx_byte (rx.rx_byte),
		.res_vld (res_vld),
		.res     (res)
	);

	hlfd_out_reg #(
		.INDEX_BITS (PAYLOAD_INDEX_BITS)
	) u_out (
		.clk                  (clk),
		.arst_n               (arst_n),
		.in_fire              (in_fire),
		.res_vld              (res_vld),
		.res                  (res),
		.out_ready            (evt.ready),
		.in_ready             (in_ready),
		.out_valid            (evt.valid),
		.event_kind           (evt.event_kind),
		.payload_byte         (evt.payload_byte),
		.byte_index           (evt.byte_index),
		.frame_payload_length (evt.frame_payload_length)
	);
endmodule

// ----- rtl/hlfd_checker.sv -----
`include "header_length_footer_deframer_unit_assert.svh"

module hlfd_checker #(
	parameter int INDEX_BITS = 20
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           rx_valid,
	input logic                           rx_ready,
	input logic                           evt_valid,
	input logic                           evt_ready,
	input logic [1:0]                     event_kind,
	input logic [hlfd_pkg::BYTE_BITS-1:0] payload_byte,
	input logic [INDEX_BITS-1:0]          byte_index,
	input logic [hlfd_pkg::LEN_BITS-1:0]  frame_payload_length
);
	import hlfd_pkg::*;

	logic rx_beat;
	logic evt_beat;
	logic stalled;
	logic verdict;

	assign rx_beat  = rx_valid && rx_ready;
	assign evt_beat = evt_valid && evt_ready;
	assign stalled  = evt_valid && !evt_ready;
	assign verdict  = evt_valid && (event_kind != EV_PAYLOAD);

	`HLFD_ASSERT_NEXT(a_evt_hold, stalled,
		evt_valid && $stable(event_kind) && $stable(frame_payload_length),
		"result beat changed while stalled")

	`HLFD_ASSERT_NEXT(a_no_spurious, evt_beat && !rx_beat, !evt_valid,
		"result beat without a new input beat")

	`HLFD_ASSERT_NOW(a_verdict_clean, verdict,
		(payload_byte == '0) && (byte_index == '0),
		"verdict carries payload byte or index")

	`HLFD_ASSERT_NOW(a_bad_len_zero, evt_valid && (event_kind == EV_BAD_LEN),
		frame_payload_length == '0,
		"length error carries nonzero payload length")
endmodule

bind header_length_footer_deframer_unit hlfd_checker #(
	.INDEX_BITS (PAYLOAD_INDEX_BITS)
) u_hlfd_checker (
	.clk                  (clk),
	.arst_n               (arst_n),
	.rx_valid             (rx.valid),
	.rx_ready             (rx.ready),
	.evt_valid            (evt.valid),
	.evt_ready            (evt.ready),
	.event_kind           (evt.event_kind),
	.payload_byte         (evt.payload_byte),
	.byte_index           (evt.byte_index),
	.frame_payload_length (evt.frame_payload_length)
);
